// ----- sv/fpf_pkg.sv -----
// Package for the fBm Perlin pixel field unit: sizes, register and command codes,
// controller/datapath structs and the gradient function. No dependencies.
package fpf_pkg;

    localparam int NUM_OCTAVES = 9;
    localparam int PERM_SIZE   = 256;
    localparam int PERM_AW     = $clog2(PERM_SIZE);
    localparam int OCT_W       = (NUM_OCTAVES > 1) ? $clog2(NUM_OCTAVES) : 1;

    localparam logic [OCT_W-1:0]   OCT_LAST  = OCT_W'(NUM_OCTAVES - 1);
    localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_SIZE - 1);

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    localparam int DIVD_W = 35;
    localparam int DIVS_W = 16;
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SEED   = 3'd0;
    localparam t_cfg_idx CFG_FREQ   = 3'd1;
    localparam t_cfg_idx CFG_LAC    = 3'd2;
    localparam t_cfg_idx CFG_WIDTH  = 3'd3;
    localparam t_cfg_idx CFG_HEIGHT = 3'd4;

    typedef logic [3:0] t_phase;
    localparam t_phase PH_COORD = 4'd0;
    localparam t_phase PH_SQ    = 4'd1;
    localparam t_phase PH_CUBE  = 4'd2;
    localparam t_phase PH_FADE  = 4'd3;
    localparam t_phase PH_HA    = 4'd4;
    localparam t_phase PH_HB    = 4'd5;
    localparam t_phase PH_HC    = 4'd6;
    localparam t_phase PH_HD    = 4'd7;
    localparam t_phase PH_DOT   = 4'd8;
    localparam t_phase PH_MULX  = 4'd9;
    localparam t_phase PH_LERPX = 4'd10;
    localparam t_phase PH_MULY  = 4'd11;
    localparam t_phase PH_SUM   = 4'd12;
    localparam t_phase PH_LAST  = PH_SUM;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_FILL,
        OP_LCG_MUL,
        OP_LCG_ADD,
        OP_RD_I,
        OP_RD_J,
        OP_WR_I,
        OP_WR_J,
        OP_DIV_X,
        OP_SET_X,
        OP_DIV_Y,
        OP_SET_Y,
        OP_STEP,
        OP_OCT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [PERM_AW-1:0] idx;
        logic [OCT_W-1:0]  oct;
        t_phase            phase;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

    function automatic logic signed [19:0] grad_dot(input logic [3:0] h,
                                                   input logic signed [17:0] x,
                                                   input logic signed [17:0] y);
        logic signed [19:0] xe;
        logic signed [19:0] ye;
        logic signed [19:0] res;
        xe = {{2{x[17]}}, x};
        ye = {{2{y[17]}}, y};
        case (h)
            4'd0:    res = xe + ye;
            4'd1:    res = ye - xe;
            4'd2:    res = xe - ye;
            4'd3:    res = -xe - ye;
            4'd4:    res = xe;
            4'd5:    res = -xe;
            4'd6:    res = xe;
            4'd7:    res = -xe;
            4'd8:    res = ye;
            4'd9:    res = -ye;
            4'd10:   res = ye;
            4'd11:   res = -ye;
            4'd12:   res = xe + ye;
            4'd13:   res = -ye;
            4'd14:   res = ye - xe;
            4'd15:   res = -ye;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ----- sv/fpf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fpf_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by shuffle and step build.
// Depends on fpf_pkg.
module fpf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fpf_pkg::DIVD_W-1:0] i_dividend,
    input  logic [fpf_pkg::DIVS_W-1:0] i_divisor,
    output logic [fpf_pkg::DIVD_W-1:0] o_quotient,
    output logic [fpf_pkg::DIVS_W-1:0] o_remainder,
    output logic                       o_busy
);

    logic                       r_busy;
    logic [fpf_pkg::DCNT_W-1:0] r_cnt;
    logic [fpf_pkg::DIVD_W-1:0] r_quo;
    logic [fpf_pkg::DIVS_W-1:0] r_rem;
    logic [fpf_pkg::DIVS_W-1:0] r_dvs;
    logic [fpf_pkg::DIVS_W:0]   n_shift;
    logic [fpf_pkg::DIVS_W:0]   n_diff;
    logic                       n_bit;

    always_comb begin
        n_shift = {r_rem, r_quo[fpf_pkg::DIVD_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_bit   = (n_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == fpf_pkg::DCNT_W'(fpf_pkg::DIVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fpf_pkg::DIVD_W-2:0], n_bit};
            r_rem <= n_bit ? n_diff[fpf_pkg::DIVS_W-1:0] : n_shift[fpf_pkg::DIVS_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_busy      = r_busy;

endmodule

// ----- sv/fpf_datapath.sv -----
// Datapath: configuration registers, permutation RAM, step tables, noise evaluator.
// Depends on fpf_pkg, fpf_ram and fpf_div.
module fpf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpf_pkg::t_cmd       i_cmd,
    output fpf_pkg::t_sts       o_sts,
    input  logic                i_cfg_we,
    input  fpf_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic [15:0]         i_pixel_x,
    input  logic [15:0]         i_pixel_y,
    output logic signed [17:0]  o_noise_value
);

    logic [31:0] r_seed;
    logic [23:0] r_freq;
    logic [23:0] r_lac;
    logic [15:0] r_w;
    logic [15:0] r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
            r_freq <= 24'd327680;
            r_lac  <= 24'd131072;
            r_w    <= 16'd1000;
            r_h    <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpf_pkg::CFG_SEED:   r_seed <= i_cfg_data;
                fpf_pkg::CFG_FREQ:   r_freq <= i_cfg_data[23:0];
                fpf_pkg::CFG_LAC:    r_lac  <= i_cfg_data[23:0];
                fpf_pkg::CFG_WIDTH:  r_w    <= i_cfg_data[15:0];
                fpf_pkg::CFG_HEIGHT: r_h    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // divider
    logic                       div_start;
    logic [fpf_pkg::DIVD_W-1:0] div_dividend;
    logic [fpf_pkg::DIVS_W-1:0] div_divisor;
    logic [fpf_pkg::DIVD_W-1:0] div_quo;
    logic [fpf_pkg::DIVS_W-1:0] div_rem;
    logic                       div_busy;

    fpf_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_busy      (div_busy)
    );

    assign o_sts.div_busy = div_busy;

    // permutation RAM
    logic                        ram_we;
    logic [fpf_pkg::PERM_AW-1:0] ram_waddr;
    logic [7:0]                  ram_wdata;
    logic [fpf_pkg::PERM_AW-1:0] ram_raddr;
    logic [7:0]                  ram_rdata;

    fpf_ram #(
        .WIDTH (8),
        .DEPTH (fpf_pkg::PERM_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic [31:0] r_x;
    logic [31:0] r_prod;
    logic [7:0]  r_pi;
    logic [31:0] r_sx;
    logic [31:0] r_sy;
    logic [31:0] r_stx [fpf_pkg::NUM_OCTAVES];
    logic [31:0] r_sty [fpf_pkg::NUM_OCTAVES];
    logic [16:0] r_px2;
    logic [16:0] r_py2;
    logic [31:0] r_cx;
    logic [31:0] r_cy;
    logic [15:0] r_t2x;
    logic [15:0] r_t2y;
    logic [15:0] r_t3x;
    logic [15:0] r_t3y;
    logic [20:0] r_qx;
    logic [20:0] r_qy;
    logic [16:0] r_u;
    logic [16:0] r_v;
    logic [7:0]  r_h0;
    logic [7:0]  r_h1;
    logic [7:0]  r_aa;
    logic [7:0]  r_ba;
    logic [7:0]  r_ab;
    logic [7:0]  r_bb;
    logic signed [19:0] r_d00;
    logic signed [19:0] r_d10;
    logic signed [19:0] r_d01;
    logic signed [19:0] r_d11;
    logic signed [38:0] r_m1;
    logic signed [38:0] r_m2;
    logic signed [38:0] r_m3;
    logic signed [19:0] r_x1;
    logic signed [19:0] r_x2;
    logic signed [23:0] r_sum;
    logic signed [17:0] r_out;

    logic [7:0]  xi;
    logic [7:0]  yi;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [31:0] n_x;
    logic [48:0] n_cxp;
    logic [48:0] n_cyp;
    logic [31:0] n_sqx;
    logic [31:0] n_sqy;
    logic [31:0] n_cbx;
    logic [31:0] n_cby;
    logic [22:0] qpx;
    logic [22:0] qnx;
    logic [22:0] qpy;
    logic [22:0] qny;
    logic [36:0] n_fdx;
    logic [36:0] n_fdy;
    logic signed [17:0] ax0;
    logic signed [17:0] ax1;
    logic signed [17:0] ay0;
    logic signed [17:0] ay1;
    logic signed [20:0] dlt1;
    logic signed [20:0] dlt2;
    logic signed [20:0] dlt3;
    logic signed [38:0] m1s;
    logic signed [38:0] m2s;
    logic signed [38:0] m3s;
    logic signed [19:0] n_noise;
    logic signed [19:0] n_wt;
    logic [55:0] n_lx;
    logic [55:0] n_ly;
    logic [8:0]  n_mod;

    always_comb begin
        xi    = r_cx[31:24];
        yi    = r_cy[31:24];
        fx    = r_cx[23:8];
        fy    = r_cy[23:8];
        n_x   = r_prod + fpf_pkg::LCG_ADD;
        n_cxp = r_px2 * r_stx[i_cmd.oct];
        n_cyp = r_py2 * r_sty[i_cmd.oct];
        n_sqx = fx * fx;
        n_sqy = fy * fy;
        n_cbx = r_t2x * fx;
        n_cby = r_t2y * fy;
        qpx   = 23'(r_t2x) * 23'd6 + 23'd655360;
        qnx   = 23'(fx) * 23'd15;
        qpy   = 23'(r_t2y) * 23'd6 + 23'd655360;
        qny   = 23'(fy) * 23'd15;
        n_fdx = r_t3x * r_qx;
        n_fdy = r_t3y * r_qy;
        ax0   = $signed({2'b00, fx});
        ax1   = ax0 - 18'sd65536;
        ay0   = $signed({2'b00, fy});
        ay1   = ay0 - 18'sd65536;
        dlt1  = {r_d10[19], r_d10} - {r_d00[19], r_d00};
        dlt2  = {r_d11[19], r_d11} - {r_d01[19], r_d01};
        dlt3  = {r_x2[19], r_x2} - {r_x1[19], r_x1};
        m1s   = r_m1 >>> 16;
        m2s   = r_m2 >>> 16;
        m3s   = r_m3 >>> 16;
        n_noise = r_x1 + m3s[19:0];
        n_wt    = n_noise >>> i_cmd.oct;
        n_lx  = r_sx * r_lac;
        n_ly  = r_sy * r_lac;
        n_mod = {1'b0, i_cmd.idx} + 9'd1;
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = {3'b000, n_x};
        div_divisor  = {7'd0, n_mod};
        case (i_cmd.op)
            fpf_pkg::OP_LCG_ADD: div_start = 1'b1;
            fpf_pkg::OP_DIV_X: begin
                div_start    = 1'b1;
                div_dividend = {r_freq, 11'd0};
                div_divisor  = (r_w == 16'd0) ? 16'd1 : r_w;
            end
            fpf_pkg::OP_DIV_Y: begin
                div_start    = 1'b1;
                div_dividend = {r_freq, 11'd0};
                div_divisor  = (r_h == 16'd0) ? 16'd1 : r_h;
            end
            default: ;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = i_cmd.idx;
        ram_wdata = i_cmd.idx;
        ram_raddr = i_cmd.idx;
        case (i_cmd.op)
            fpf_pkg::OP_FILL: ram_we = 1'b1;
            fpf_pkg::OP_RD_J: ram_raddr = div_rem[7:0];
            fpf_pkg::OP_WR_I: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            fpf_pkg::OP_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = div_rem[7:0];
                ram_wdata = r_pi;
            end
            fpf_pkg::OP_OCT: begin
                case (i_cmd.phase)
                    fpf_pkg::PH_SQ:   ram_raddr = yi;
                    fpf_pkg::PH_CUBE: ram_raddr = yi + 8'd1;
                    fpf_pkg::PH_FADE: ram_raddr = xi + r_h0;
                    fpf_pkg::PH_HA:   ram_raddr = xi + r_h0 + 8'd1;
                    fpf_pkg::PH_HB:   ram_raddr = xi + r_h1;
                    fpf_pkg::PH_HC:   ram_raddr = xi + r_h1 + 8'd1;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fpf_pkg::OP_LATCH: begin
                r_px2 <= {i_pixel_x, 1'b1};
                r_py2 <= {i_pixel_y, 1'b1};
                r_sum <= '0;
            end
            fpf_pkg::OP_FILL:    r_x <= r_seed;
            fpf_pkg::OP_LCG_MUL: r_prod <= r_x * fpf_pkg::LCG_MUL;
            fpf_pkg::OP_LCG_ADD: r_x <= n_x;
            fpf_pkg::OP_RD_J:    r_pi <= ram_rdata;
            fpf_pkg::OP_SET_X:   r_sx <= div_quo[31:0];
            fpf_pkg::OP_SET_Y:   r_sy <= div_quo[31:0];
            fpf_pkg::OP_STEP: begin
                r_stx[i_cmd.oct] <= r_sx;
                r_sty[i_cmd.oct] <= r_sy;
                r_sx <= n_lx[47:16];
                r_sy <= n_ly[47:16];
            end
            fpf_pkg::OP_OCT: begin
                case (i_cmd.phase)
                    fpf_pkg::PH_COORD: begin
                        r_cx <= n_cxp[32:1];
                        r_cy <= n_cyp[32:1];
                    end
                    fpf_pkg::PH_SQ: begin
                        r_t2x <= n_sqx[31:16];
                        r_t2y <= n_sqy[31:16];
                    end
                    fpf_pkg::PH_CUBE: begin
                        r_t3x <= n_cbx[31:16];
                        r_t3y <= n_cby[31:16];
                        r_qx  <= (qpx >= qnx) ? 21'(qpx - qnx) : 21'd0;
                        r_qy  <= (qpy >= qny) ? 21'(qpy - qny) : 21'd0;
                        r_h0  <= ram_rdata;
                    end
                    fpf_pkg::PH_FADE: begin
                        r_u  <= n_fdx[32:16];
                        r_v  <= n_fdy[32:16];
                        r_h1 <= ram_rdata;
                    end
                    fpf_pkg::PH_HA: r_aa <= ram_rdata;
                    fpf_pkg::PH_HB: r_ba <= ram_rdata;
                    fpf_pkg::PH_HC: r_ab <= ram_rdata;
                    fpf_pkg::PH_HD: r_bb <= ram_rdata;
                    fpf_pkg::PH_DOT: begin
                        r_d00 <= fpf_pkg::grad_dot(r_aa[3:0], ax0, ay0);
                        r_d10 <= fpf_pkg::grad_dot(r_ba[3:0], ax1, ay0);
                        r_d01 <= fpf_pkg::grad_dot(r_ab[3:0], ax0, ay1);
                        r_d11 <= fpf_pkg::grad_dot(r_bb[3:0], ax1, ay1);
                    end
                    fpf_pkg::PH_MULX: begin
                        r_m1 <= $signed({1'b0, r_u}) * dlt1;
                        r_m2 <= $signed({1'b0, r_u}) * dlt2;
                    end
                    fpf_pkg::PH_LERPX: begin
                        r_x1 <= r_d00 + m1s[19:0];
                        r_x2 <= r_d01 + m2s[19:0];
                    end
                    fpf_pkg::PH_MULY: r_m3 <= $signed({1'b0, r_v}) * dlt3;
                    fpf_pkg::PH_SUM:  r_sum <= r_sum + {{4{n_wt[19]}}, n_wt};
                    default: ;
                endcase
            end
            fpf_pkg::OP_OUT: begin
                if (r_sum > 24'sd131071) begin
                    r_out <= 18'sh1FFFF;
                end else if (r_sum < -24'sd131072) begin
                    r_out <= 18'sh20000;
                end else begin
                    r_out <= r_sum[17:0];
                end
            end
            default: ;
        endcase
    end

    assign o_noise_value = r_out;

endmodule

// ----- sv/fpf_ctrl.sv -----
// Controller: sequences shuffle, step build and octave evaluation, owns table flags
// and the result valid. Depends on fpf_pkg.
module fpf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic              i_cfg_we,
    input  fpf_pkg::t_cfg_idx i_cfg_index,
    input  fpf_pkg::t_sts     i_sts,
    output fpf_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_FILL, S_MUL, S_ADD, S_DWAIT, S_RDI, S_RDJ, S_WRI, S_WRJ,
        S_DIVX, S_WAITX, S_SETX, S_DIVY, S_WAITY, S_SETY, S_STEP, S_OCT, S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [fpf_pkg::PERM_AW-1:0] r_idx, n_idx;
    logic [fpf_pkg::OCT_W-1:0]   r_oct, n_oct;
    fpf_pkg::t_phase             r_phase, n_phase;
    logic                        r_perm_rdy, n_perm_rdy;
    logic                        r_step_rdy, n_step_rdy;
    logic                        r_out_valid, n_out_valid;
    fpf_pkg::t_cmd               n_cmd;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_oct       = r_oct;
        n_phase     = r_phase;
        n_perm_rdy  = r_perm_rdy;
        n_step_rdy  = r_step_rdy;
        n_out_valid = r_out_valid && i_out_stall;
        n_cmd.op    = fpf_pkg::OP_NONE;
        n_cmd.idx   = r_idx;
        n_cmd.oct   = r_oct;
        n_cmd.phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.op = fpf_pkg::OP_LATCH;
                    n_oct    = '0;
                    n_phase  = fpf_pkg::PH_COORD;
                    n_idx    = '0;
                    if (!r_perm_rdy) begin
                        n_state = S_FILL;
                    end else if (!r_step_rdy) begin
                        n_state = S_DIVX;
                    end else begin
                        n_state = S_OCT;
                    end
                end
            end
            S_FILL: begin
                n_cmd.op = fpf_pkg::OP_FILL;
                if (r_idx == fpf_pkg::PERM_LAST) begin
                    n_state = S_MUL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MUL: begin
                n_cmd.op = fpf_pkg::OP_LCG_MUL;
                n_state  = S_ADD;
            end
            S_ADD: begin
                n_cmd.op = fpf_pkg::OP_LCG_ADD;
                n_state  = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                n_cmd.op = fpf_pkg::OP_RD_I;
                n_state  = S_RDJ;
            end
            S_RDJ: begin
                n_cmd.op = fpf_pkg::OP_RD_J;
                n_state  = S_WRI;
            end
            S_WRI: begin
                n_cmd.op = fpf_pkg::OP_WR_I;
                n_state  = S_WRJ;
            end
            S_WRJ: begin
                n_cmd.op = fpf_pkg::OP_WR_J;
                if (r_idx == fpf_pkg::PERM_AW'(1)) begin
                    n_perm_rdy = 1'b1;
                    n_state    = r_step_rdy ? S_OCT : S_DIVX;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_MUL;
                end
            end
            S_DIVX: begin
                n_cmd.op = fpf_pkg::OP_DIV_X;
                n_state  = S_WAITX;
            end
            S_WAITX: begin
                if (!i_sts.div_busy) begin
                    n_state = S_SETX;
                end
            end
            S_SETX: begin
                n_cmd.op = fpf_pkg::OP_SET_X;
                n_state  = S_DIVY;
            end
            S_DIVY: begin
                n_cmd.op = fpf_pkg::OP_DIV_Y;
                n_state  = S_WAITY;
            end
            S_WAITY: begin
                if (!i_sts.div_busy) begin
                    n_state = S_SETY;
                end
            end
            S_SETY: begin
                n_cmd.op = fpf_pkg::OP_SET_Y;
                n_oct    = '0;
                n_state  = S_STEP;
            end
            S_STEP: begin
                n_cmd.op = fpf_pkg::OP_STEP;
                if (r_oct == fpf_pkg::OCT_LAST) begin
                    n_oct      = '0;
                    n_step_rdy = 1'b1;
                    n_state    = S_OCT;
                end else begin
                    n_oct = r_oct + 1'b1;
                end
            end
            S_OCT: begin
                n_cmd.op = fpf_pkg::OP_OCT;
                if (r_phase == fpf_pkg::PH_LAST) begin
                    n_phase = fpf_pkg::PH_COORD;
                    if (r_oct == fpf_pkg::OCT_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_oct = r_oct + 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_cmd.op    = fpf_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) begin
            case (i_cfg_index)
                fpf_pkg::CFG_SEED: begin
                    n_perm_rdy = 1'b0;
                    n_step_rdy = 1'b0;
                end
                fpf_pkg::CFG_FREQ, fpf_pkg::CFG_LAC, fpf_pkg::CFG_WIDTH,
                fpf_pkg::CFG_HEIGHT: n_step_rdy = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_oct       <= '0;
            r_phase     <= fpf_pkg::PH_COORD;
            r_perm_rdy  <= 1'b0;
            r_step_rdy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_oct       <= n_oct;
            r_phase     <= n_phase;
            r_perm_rdy  <= n_perm_rdy;
            r_step_rdy  <= n_step_rdy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = r_state == S_IDLE && !i_in_valid ? n_cmd : n_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/fbm_perlin_pixel_field_unit.sv -----
// Top level of the fBm Perlin pixel field unit: joins controller and datapath.
// Depends on fpf_pkg, fpf_ctrl and fpf_datapath.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   input    | i_in_valid / o_in_stall    | i_pixel_x, i_pixel_y
//   result   | o_out_valid / i_out_stall  | o_noise_value
//   config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item at a time; the octaves take turns in the shared noise evaluator.
// After reset or a seed write the first item first shuffles the permutation RAM:
// a fill, then a swap for each entry from the last down to entry 1 (LCG, then
// divider, one bit a cycle). After a write to the seed, frequency, lacunarity,
// width or height register the first item rebuilds the steps: two divisions,
// then one step per octave. A stalled result holds until taken.
module fbm_perlin_pixel_field_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_pixel_x,
    input  logic [15:0]        i_pixel_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    fpf_pkg::t_cmd cmd;
    fpf_pkg::t_sts sts;
    logic          cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    fpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fpf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_noise_value (o_noise_value)
    );

endmodule

// ----- dv/fpf_checker.sv -----
// Checker for the fBm Perlin pixel field unit: watches the config, pixel and result
// channels, predicts every noise value and compares it with the block's answer.
// Depends on fpf_pkg.
module fpf_checker
    import fpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [15:0]        i_pixel_x,
    input  logic [15:0]        i_pixel_y,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [17:0] i_noise_value,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRAD_X [16] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0, 1, 0, -1, 0};
    localparam int GRAD_Y [16] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1, 1, -1, 1, -1};

    logic [31:0] seed_q;
    logic [23:0] freq_q;
    logic [23:0] lac_q;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [7:0]  perm_tab [PERM_SIZE];
    bit          perm_valid;
    logic [31:0] step_x [NUM_OCTAVES];
    logic [31:0] step_y [NUM_OCTAVES];
    bit          steps_valid;

    logic signed [17:0] noise_queue [$];

    function automatic void shuffle_perm();
        logic [31:0] x;
        logic [31:0] j;
        logic [7:0]  t;
        x = seed_q;
        for (int i = 0; i < PERM_SIZE; i++) perm_tab[i] = 8'(i);
        for (int i = PERM_SIZE - 1; i > 0; i--) begin
            x = x * LCG_MUL + LCG_ADD;
            j = x % 32'(i + 1);
            t = perm_tab[i];
            perm_tab[i] = perm_tab[j[7:0]];
            perm_tab[j[7:0]] = t;
        end
        perm_valid = 1;
    endfunction

    function automatic void build_octave_steps();
        logic [63:0] k;
        logic [63:0] w;
        logic [63:0] h;
        logic [31:0] sx;
        logic [31:0] sy;
        w = (width_q == 0) ? 64'd1 : 64'(width_q);
        h = (height_q == 0) ? 64'd1 : 64'(height_q);
        k = 64'(freq_q) << 11;
        sx = 32'(k / w);
        sy = 32'(k / h);
        for (int o = 0; o < NUM_OCTAVES; o++) begin
            step_x[o] = sx;
            step_y[o] = sy;
            sx = 32'((64'(sx) * 64'(lac_q)) >> 16);
            sy = 32'((64'(sy) * 64'(lac_q)) >> 16);
        end
        steps_valid = 1;
    endfunction

    function automatic longint fade_q16(longint t);
        longint t2;
        longint t3;
        longint q;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        q = 6 * t2 - 15 * t + 10 * 65536;
        if (q < 0) q = 0;
        return (t3 * q) >>> 16;
    endfunction

    function automatic longint corner_dot(logic [7:0] hsh, longint x, longint y);
        return GRAD_X[hsh[3:0]] * x + GRAD_Y[hsh[3:0]] * y;
    endfunction

    function automatic longint blend_q16(longint a, longint b, longint f);
        return a + ((f * (b - a)) >>> 16);
    endfunction

    function automatic longint lattice_noise(logic [31:0] cx, logic [31:0] cy);
        logic [7:0] xi;
        logic [7:0] yi;
        logic [7:0] h0;
        logic [7:0] h1;
        longint fx;
        longint fy;
        longint u;
        longint v;
        longint x1;
        longint x2;
        xi = cx[31:24];
        yi = cy[31:24];
        fx = longint'(cx[23:8]);
        fy = longint'(cy[23:8]);
        u = fade_q16(fx);
        v = fade_q16(fy);
        h0 = perm_tab[yi];
        h1 = perm_tab[8'(yi + 8'd1)];
        x1 = blend_q16(corner_dot(perm_tab[8'(xi + h0)], fx, fy),
                       corner_dot(perm_tab[8'(xi + 8'd1 + h0)], fx - 65536, fy), u);
        x2 = blend_q16(corner_dot(perm_tab[8'(xi + h1)], fx, fy - 65536),
                       corner_dot(perm_tab[8'(xi + 8'd1 + h1)], fx - 65536, fy - 65536), u);
        return blend_q16(x1, x2, v);
    endfunction

    function automatic logic signed [17:0] fbm_sum(logic [15:0] px, logic [15:0] py);
        logic [63:0] px2;
        logic [63:0] py2;
        logic [31:0] cx;
        logic [31:0] cy;
        longint      acc;
        if (!perm_valid) shuffle_perm();
        if (!steps_valid) build_octave_steps();
        px2 = (64'(px) << 1) + 64'd1;
        py2 = (64'(py) << 1) + 64'd1;
        acc = 0;
        for (int o = 0; o < NUM_OCTAVES; o++) begin
            cx = 32'((px2 * 64'(step_x[o])) >> 1);
            cy = 32'((py2 * 64'(step_y[o])) >> 1);
            acc += lattice_noise(cx, cy) >>> o;
        end
        if (acc > 131071) acc = 131071;
        if (acc < -131072) acc = -131072;
        return 18'(acc);
    endfunction

    always @(posedge i_clk) begin
        logic signed [17:0] want;
        if (!i_rst_n) begin
            seed_q = '0;
            freq_q = 24'd327680;
            lac_q = 24'd131072;
            width_q = 16'd1000;
            height_q = 16'd1000;
            perm_valid = 0;
            steps_valid = 0;
            noise_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEED: begin
                        seed_q = i_cfg_data;
                        perm_valid = 0;
                        steps_valid = 0;
                    end
                    CFG_FREQ: begin
                        freq_q = i_cfg_data[23:0];
                        steps_valid = 0;
                    end
                    CFG_LAC: begin
                        lac_q = i_cfg_data[23:0];
                        steps_valid = 0;
                    end
                    CFG_WIDTH: begin
                        width_q = i_cfg_data[15:0];
                        steps_valid = 0;
                    end
                    CFG_HEIGHT: begin
                        height_q = i_cfg_data[15:0];
                        steps_valid = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) noise_queue.push_back(fbm_sum(i_pixel_x, i_pixel_y));
            if (i_out_valid && !i_out_stall) begin
                if (noise_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected noise result %0d", i_noise_value);
                end else begin
                    want = noise_queue.pop_front();
                    if (want !== i_noise_value) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("noise mismatch: expected %0d actual %0d",
                                     want, i_noise_value);
                    end
                end
            end
        end
        o_pending = noise_queue.size();
    end

endmodule

// ----- dv/tb_fbm_perlin_pixel_field_unit.sv -----
// Testbench top for the fBm Perlin pixel field unit: clock, reset, config phases,
// pixel stimulus, random idling and the verdict. Depends on fpf_pkg and fpf_checker.
module tb_fbm_perlin_pixel_field_unit;
    import fpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_cfg_idx CFG_SPARE_A = 3'd5;
    localparam t_cfg_idx CFG_SPARE_B = 3'd6;
    localparam t_cfg_idx CFG_SPARE_C = 3'd7;
    localparam int       CYCLE_LIMIT = 3000000;
    localparam int       NUM_PHASES  = 9;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [15:0]        i_pixel_x = '0;
    logic [15:0]        i_pixel_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic signed [17:0] o_noise_value;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    int  stall_left = 0;
    bit  calm = 0;

    fbm_perlin_pixel_field_unit dut (.*);

    fpf_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_pixel_x, .i_pixel_y,
        .i_out_valid(o_out_valid), .i_out_stall, .i_noise_value(o_noise_value),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (!calm && i_rst_n && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 10);
        end
        i_out_stall <= (stall_left != 0);
    end

    task automatic send_pixel(input logic [15:0] px, input logic [15:0] py);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h0001, 16'h0001);
        send_pixel(16'h7FFF, 16'h8000);
        send_pixel(16'h5555, 16'hAAAA);
        send_pixel(16'hAAAA, 16'h5555);
        send_pixel(16'd499, 16'd500);
        send_pixel(16'd999, 16'd999);
        for (int n = 0; n < 6; n++) send_pixel(16'($urandom), 16'($urandom));

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            drain();
            case (ph)
                1: begin
                    write_reg(CFG_SEED, 32'hFFFF_FFFF);
                    write_reg(CFG_FREQ, 32'hFFFF_FFFF);
                    write_reg(CFG_LAC, 32'h00FF_FFFF);
                    write_reg(CFG_WIDTH, 32'd1);
                    write_reg(CFG_HEIGHT, 32'd1);
                end
                2: begin
                    write_reg(CFG_FREQ, 32'd0);
                    write_reg(CFG_LAC, 32'd0);
                end
                3: begin
                    write_reg(CFG_SEED, 32'd0);
                    write_reg(CFG_FREQ, 32'd327680);
                    write_reg(CFG_LAC, 32'h0001_0000);
                    write_reg(CFG_WIDTH, 32'd0);
                    write_reg(CFG_HEIGHT, 32'hFFFF_0000);
                end
                4: begin
                    write_reg(CFG_WIDTH, 32'hFFFF);
                    write_reg(CFG_HEIGHT, 32'hFFFF);
                    write_reg(CFG_LAC, 32'd131072);
                    write_reg(CFG_FREQ, 32'h00FF_FFFF);
                end
                5: begin
                    write_reg(CFG_SPARE_A, $urandom);
                    write_reg(CFG_SPARE_B, $urandom);
                    write_reg(CFG_SPARE_C, $urandom);
                end
                default: begin
                    write_reg(CFG_SEED, $urandom);
                    write_reg(CFG_FREQ, $urandom);
                    write_reg(CFG_LAC, {8'($urandom_range(0, 255)), 8'($urandom),
                                        16'($urandom)});
                    write_reg(CFG_WIDTH, {16'($urandom), 16'($urandom_range(0, 4000))});
                    write_reg(CFG_HEIGHT, $urandom);
                end
            endcase
            i_cfg_valid <= 0;
            if (ph == NUM_PHASES) calm = 1;
            if (ph == 1) begin
                send_pixel(16'h0000, 16'h0000);
                send_pixel(16'hFFFF, 16'hFFFF);
                send_pixel(16'h8000, 16'h7FFF);
            end
            for (int n = 0; n < 115; n++) send_pixel(16'($urandom), 16'($urandom));
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
